FILE: rtl/core/dsc_pkg.sv
// types, constants and helpers shared by the segment coalescer files
`timescale 1ns / 1ps

package dsc_pkg;

	localparam int unsigned PAGE_BYTES_DEF = 4096;
	localparam int unsigned FIFO_DEPTH_DEF = 4;
	localparam int unsigned MAX_SEG_W      = 31;
	localparam logic [MAX_SEG_W-1:0] MAX_SEG_RESET = 31'd65536;

	typedef struct packed {
		logic [31:0] chunk_virt;
		logic [31:0] chunk_phys;
		logic [31:0] bytes_left;
	} chunk_t;

	typedef struct packed {
		logic [31:0] seg_virt;
		logic [31:0] seg_phys;
		logic [31:0] seg_bytes;
		logic        seg_final;
	} seg_t;

	// results produced by one chunk, compacted so that first is filled before second
	typedef struct packed {
		logic [1:0] count;
		seg_t       first;
		seg_t       second;
	} push_t;

endpackage

FILE: rtl/core/dsc_core.sv
// coalescing logic: open segment state, join decision and emitted segments
`timescale 1ns / 1ps

module dsc_core #(
	parameter int unsigned PAGE_BYTES = dsc_pkg::PAGE_BYTES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [dsc_pkg::MAX_SEG_W-1:0] cfg_data,
	input  logic                         enable,
	input  dsc_pkg::chunk_t              chunk,
	output dsc_pkg::push_t               push
);

	localparam int unsigned OFFS_W = $clog2(PAGE_BYTES);
	localparam logic [31:0] PAGE_SPAN = 32'(PAGE_BYTES);
	localparam logic [31:0] OFFS_MASK = PAGE_SPAN - 32'd1;

	logic [dsc_pkg::MAX_SEG_W-1:0] max_seg_q;
	logic [31:0] open_virt_q, open_phys_q, open_bytes_q, prev_page_q;

	logic [31:0] page, to_end, len, nxt_page;
	logic [32:0] grown;
	logic        left_zero, is_open, last, join_ok, emit_close;
	logic [31:0] new_virt, new_phys, new_bytes;
	dsc_pkg::seg_t closed_seg, final_seg;

	always_comb begin
		page      = chunk.chunk_phys & ~OFFS_MASK;
		to_end    = PAGE_SPAN - {{(32-OFFS_W){1'b0}}, chunk.chunk_phys[OFFS_W-1:0]};
		left_zero = (chunk.bytes_left == 32'd0);
		is_open   = (open_bytes_q != 32'd0);
		len       = (chunk.bytes_left < to_end) ? chunk.bytes_left : to_end;
		last      = (chunk.bytes_left <= to_end);
		nxt_page  = prev_page_q + PAGE_SPAN;
		grown     = {1'b0, open_bytes_q} + {1'b0, len};
		join_ok   = is_open && (page == nxt_page) && (grown < {2'b00, max_seg_q});
		emit_close = is_open && !join_ok;

		if (join_ok) begin
			new_virt  = open_virt_q;
			new_phys  = open_phys_q;
			new_bytes = grown[31:0];
		end else begin
			new_virt  = chunk.chunk_virt;
			new_phys  = chunk.chunk_phys;
			new_bytes = len;
		end

		closed_seg = '{seg_virt: open_virt_q, seg_phys: open_phys_q,
			seg_bytes: open_bytes_q, seg_final: 1'b0};
		final_seg  = '{seg_virt: new_virt, seg_phys: new_phys,
			seg_bytes: new_bytes, seg_final: 1'b1};

		push.second = final_seg;
		if (left_zero) begin
			// empty chunk only flushes whatever is open
			push.count = {1'b0, is_open};
			push.first = closed_seg;
			push.first.seg_final = 1'b1;
		end else begin
			push.count = {1'b0, emit_close} + {1'b0, last};
			push.first = emit_close ? closed_seg : final_seg;
		end
		if (!enable) begin
			push.count = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_seg_q <= dsc_pkg::MAX_SEG_RESET;
		end else if (cfg_we) begin
			max_seg_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_virt_q  <= '0;
			open_phys_q  <= '0;
			open_bytes_q <= '0;
			prev_page_q  <= '0;
		end else if (enable) begin
			if ((left_zero && is_open) || (!left_zero && last)) begin
				open_virt_q  <= '0;
				open_phys_q  <= '0;
				open_bytes_q <= '0;
				prev_page_q  <= '0;
			end else if (!left_zero) begin
				open_virt_q  <= new_virt;
				open_phys_q  <= new_phys;
				open_bytes_q <= new_bytes;
				prev_page_q  <= page;
			end
		end
	end

endmodule

FILE: rtl/core/dsc_out_fifo.sv
// result queue: takes up to two segments a cycle, hands out one per transfer
`timescale 1ns / 1ps

module dsc_out_fifo #(
	parameter int unsigned DEPTH = dsc_pkg::FIFO_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  dsc_pkg::push_t push,
	output logic           room,
	output logic           out_valid,
	input  logic           out_stall,
	output dsc_pkg::seg_t  out_data
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (p == LAST_PTR) ? '0 : p + PTR_W'(1);
	endfunction

	dsc_pkg::seg_t    mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q, wptr_1, wptr_2;
	logic [CNT_W-1:0] count_q;
	logic             pop;

	assign wptr_1    = ptr_inc(wptr_q);
	assign wptr_2    = ptr_inc(wptr_1);
	assign out_valid = (count_q != '0);
	assign out_data  = mem_q[rptr_q];
	assign pop       = out_valid && !out_stall;
	assign room      = (count_q <= CNT_W'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[wptr_1] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			unique case (push.count)
				2'd1:    wptr_q <= wptr_1;
				2'd2:    wptr_q <= wptr_2;
				default: wptr_q <= wptr_q;
			endcase
			if (pop) begin
				rptr_q <= ptr_inc(rptr_q);
			end
			count_q <= count_q + CNT_W'(push.count) - CNT_W'(pop);
		end
	end

endmodule

FILE: rtl/core/dma_segment_coalescer.sv
// top level of the dma scatter-gather segment coalescer
//
//  channel  direction  handshake        payload
//  in       input      in_valid/stall   chunk_t  (chunk_virt, chunk_phys, bytes_left)
//  out      output     out_valid/stall  seg_t    (seg_virt, seg_phys, seg_bytes, seg_final)
//  cfg      input      cfg_valid/ready  max_segment_bytes, 31 bits
//
// one chunk per cycle while the input is not stalled: a chunk sits in the input register,
// where the join compare and size add run, and its segments enter the result queue
// a chunk that yields two segments uses two output transfers, so the output side sets the pace
// the input stalls while chunk_s1 is valid and the result queue cannot take two more segments
// reset clears the open segment and the queue; cfg is always ready
`timescale 1ns / 1ps

module dma_segment_coalescer #(
	parameter int unsigned PAGE_BYTES = dsc_pkg::PAGE_BYTES_DEF,
	parameter int unsigned FIFO_DEPTH = dsc_pkg::FIFO_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  dsc_pkg::chunk_t               in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output dsc_pkg::seg_t                 out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [dsc_pkg::MAX_SEG_W-1:0] cfg_data
);

	dsc_pkg::chunk_t chunk_s1;
	logic            valid_s1;
	logic            room, fire_s1;
	dsc_pkg::push_t  push;

	assign cfg_ready = 1'b1;
	assign fire_s1   = valid_s1 && room;
	assign in_stall  = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			chunk_s1 <= in_data;
		end
	end

	dsc_core #(
		.PAGE_BYTES(PAGE_BYTES)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_valid && cfg_ready),
		.cfg_data(cfg_data),
		.enable  (fire_s1),
		.chunk   (chunk_s1),
		.push    (push)
	);

	dsc_out_fifo #(
		.DEPTH(FIFO_DEPTH)
	) u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (room),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

endmodule
